@@ hw/rtl/lsip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lsip_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int WIDTH_DEFAULT = 32;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int AMOUNT_W = 9;

  localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_AMT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_TO   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_ALL  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_PEEK     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsip_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lsip_ram #(
  parameter int DEPTH = lsip_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = lsip_pkg::WIDTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lifo_stack_indexed_peek.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Fields
// request   req_valid / req_stall   opcode, push_value, amount
// response  rsp_valid / rsp_stall   ok, read_value, depth_after
//
// Push, pop amount, pop to index, pop all and failed requests: response valid in the cycle after the request is taken.
// Pop and peek that hit: response after the read state, set by the registered read of the word memory.
// One request in flight; a new one is taken when the response register is free
// or is being taken in the same cycle.
// Reset clears the depth count, state and response valid and holds off requests;
// the word memory needs no clearing pass.
module lifo_stack_indexed_peek #(
  parameter int DEPTH = lsip_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = lsip_pkg::WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic [lsip_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [lsip_pkg::VALUE_W-1:0]   push_value,
  input  wire logic [lsip_pkg::AMOUNT_W-1:0]  amount,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic                                ok,
  output logic      [lsip_pkg::VALUE_W-1:0]   read_value,
  output logic      [lsip_pkg::AMOUNT_W-1:0]  depth_after
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > lsip_pkg::AMOUNT_W + 1) ? CW : lsip_pkg::AMOUNT_W + 1;
  localparam int MW = (WIDTH > lsip_pkg::VALUE_W) ? WIDTH : lsip_pkg::VALUE_W;

  lsip_pkg::state_t state;
  logic [CW-1:0]    depth;
  logic [CW-1:0]    depth_next;
  logic             ok_next;
  logic             rd_req;
  logic             wr_req;
  logic [AW-1:0]    raddr;
  logic [CW-1:0]    depth_m1;
  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    amt_x;
  logic [XW-1:0]    amt_p1;
  logic [XW-1:0]    peek_idx;
  logic [XW-1:0]    dn_x;
  logic [WIDTH-1:0] rdata;
  logic [MW-1:0]    rdata_x;
  logic             accept;
  logic             taken;

  assign req_stall = rst ||
                     !((state == lsip_pkg::ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = req_valid && !req_stall;
  assign taken     = rsp_valid && !rsp_stall;

  assign cnt_x    = XW'(depth);
  assign amt_x    = XW'(amount);
  assign amt_p1   = amt_x + XW'(1);
  assign depth_m1 = depth - CW'(1);
  assign peek_idx = cnt_x - amt_x - XW'(1);
  assign dn_x     = XW'(depth_next);
  assign rdata_x  = MW'(rdata);

  always_comb begin
    depth_next = depth;
    ok_next    = 1'b0;
    rd_req     = 1'b0;
    wr_req     = 1'b0;
    raddr      = '0;
    unique case (opcode)
      lsip_pkg::OP_PUSH: begin
        if (cnt_x < XW'(DEPTH)) begin
          wr_req     = 1'b1;
          depth_next = depth + CW'(1);
          ok_next    = 1'b1;
        end
      end
      lsip_pkg::OP_POP: begin
        if (depth != '0) begin
          depth_next = depth_m1;
          raddr      = depth_m1[AW-1:0];
          rd_req     = 1'b1;
          ok_next    = 1'b1;
        end
      end
      lsip_pkg::OP_POP_AMT: begin
        if (amt_x <= cnt_x) begin
          depth_next = CW'(cnt_x - amt_x);
          ok_next    = 1'b1;
        end else begin
          depth_next = '0;
        end
      end
      lsip_pkg::OP_POP_TO: begin
        if (cnt_x > amt_p1) begin
          depth_next = CW'(amt_p1);
        end
        ok_next = 1'b1;
      end
      lsip_pkg::OP_POP_ALL: begin
        depth_next = '0;
        ok_next    = 1'b1;
      end
      lsip_pkg::OP_PEEK: begin
        if (amt_x < cnt_x) begin
          raddr   = peek_idx[AW-1:0];
          rd_req  = 1'b1;
          ok_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  lsip_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && wr_req),
    .waddr (depth[AW-1:0]),
    .wdata (WIDTH'(push_value)),
    .re    (accept && rd_req),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lsip_pkg::ST_IDLE;
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        lsip_pkg::ST_IDLE: begin
          if (accept) begin
            depth     <= depth_next;
            rsp_valid <= !rd_req;
            if (rd_req) begin
              state <= lsip_pkg::ST_READ;
            end
          end else if (taken) begin
            rsp_valid <= 1'b0;
          end
        end
        lsip_pkg::ST_READ: begin
          rsp_valid <= 1'b1;
          state     <= lsip_pkg::ST_IDLE;
        end
        default: begin
          state <= lsip_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok          <= ok_next;
      depth_after <= dn_x[lsip_pkg::AMOUNT_W-1:0];
      read_value  <= '0;
    end else if (state == lsip_pkg::ST_READ) begin
      read_value  <= rdata_x[lsip_pkg::VALUE_W-1:0];
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(depth) <= XW'(DEPTH))
    else $error("depth count exceeds capacity");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == lsip_pkg::ST_READ |=> state == lsip_pkg::ST_IDLE && rsp_valid)
    else $error("memory read did not complete into the response");

  a_read_blocks_req: assert property (@(posedge clk) disable iff (rst)
    state == lsip_pkg::ST_READ |-> req_stall)
    else $error("request taken during memory read");

  a_pop_all_empties: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == lsip_pkg::OP_POP_ALL |=> rsp_valid && ok && depth == '0)
    else $error("pop all did not empty the stack");

endmodule

`default_nettype wire
